// ===== hdl/tsc_pkg.sv =====
// Shared types and constants for the Taylor sine/cosine block.
package tsc_pkg;

  localparam int unsigned AngleWidth = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PolyFrac   = 28;
  localparam int unsigned MagWidth   = 30;
  localparam int unsigned ProdWidth  = 64;
  localparam int unsigned RndWidth   = ProdWidth - PolyFrac;

  // pi with 60 fraction bits
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;

  // floor(2^k / c) reciprocals for the three series divisors
  localparam logic [31:0] Recip3  = 32'd2863311530;  // k = 33
  localparam logic [31:0] Recip5  = 32'd3435973836;  // k = 34
  localparam logic [31:0] Recip21 = 32'd3272356035;  // k = 36

  typedef struct packed {
    logic                neg;
    logic [MagWidth-1:0] mag;
  } tsc_job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_REDUCE,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_POST,
    BK_OUT
  } bk_state_e;

  typedef enum logic [2:0] {
    ST_SQ,
    ST_CUBE,
    ST_DIV3,
    ST_MUL5,
    ST_DIV5,
    ST_MUL7,
    ST_DIV21
  } bk_step_e;

endpackage

// ===== hdl/tsc_front.sv =====
// Request intake: cosine offset, range reduction and magnitude/sign split.
module tsc_front import tsc_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  mode_i,
  input  logic [AngleWidth-1:0] angle_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output tsc_job_t              job_o
);

  localparam logic [63:0] PiA     = (PiQ60 + (64'd1 << (59 - ANGLE_FRAC_BITS)))
                                    >> (60 - ANGLE_FRAC_BITS);
  localparam logic [63:0] HalfPiA = (PiQ60 + (64'd1 << (60 - ANGLE_FRAC_BITS)))
                                    >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TwoPiA  = PiA << 1;
  // 2pi > 4, so 2pi << (30 - F) exceeds any 32-bit magnitude
  localparam int unsigned Steps   = 31 - ANGLE_FRAC_BITS;
  localparam int unsigned CntW    = $clog2(Steps);
  localparam logic [63:0] DivInit = TwoPiA << (30 - ANGLE_FRAC_BITS);

  fr_state_e state_q, state_d;

  logic [31:0]     rem_q, rem_d;
  logic [32:0]     dsh_q, dsh_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;

  logic        load;
  logic        step;
  logic [33:0] x_ext;
  logic [33:0] x_abs;
  logic [31:0] mag;
  logic [31:0] mag_sh;
  logic        wrap;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (start_i) state_d = FR_REDUCE;
      end
      FR_REDUCE: begin
        if (cnt_q == '0) state_d = FR_PUSH;
      end
      FR_PUSH: begin
        if (!q_full_i) state_d = FR_IDLE;
      end
      default: state_d = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o = 1'b1;
    load   = 1'b0;
    step   = 1'b0;
    push_o = 1'b0;
    case (state_q)
      FR_IDLE: begin
        busy_o = 1'b0;
        load   = start_i;
      end
      FR_REDUCE: step   = 1'b1;
      FR_PUSH:   push_o = !q_full_i;
      default: ;
    endcase
  end

  always_comb begin
    x_ext = {{2{angle_i[AngleWidth-1]}}, angle_i} + (mode_i ? HalfPiA[33:0] : 34'd0);
    x_abs = x_ext[33] ? (34'd0 - x_ext) : x_ext;
  end

  // restoring reduction modulo 2pi, one divisor shift per cycle
  always_comb begin
    rem_d = rem_q;
    dsh_d = dsh_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    if (load) begin
      rem_d = x_abs[31:0];
      dsh_d = DivInit[32:0];
      cnt_d = CntW'(Steps - 1);
      neg_d = x_ext[33];
    end else if (step) begin
      if ({1'b0, rem_q} >= dsh_q) rem_d = rem_q - dsh_q[31:0];
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
    end
  end

  // remainder above pi folds to the other side
  always_comb begin
    wrap   = {32'd0, rem_q} > PiA;
    mag    = wrap ? (TwoPiA[31:0] - rem_q) : rem_q;
    mag_sh = mag << (PolyFrac - ANGLE_FRAC_BITS);
    job_o.neg = wrap ? !neg_q : neg_q;
    job_o.mag = mag_sh[MagWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

endmodule

// ===== hdl/tsc_queue.sv =====
// Two-entry job queue between intake and series evaluation.
module tsc_queue import tsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tsc_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output tsc_job_t job_o
);

  tsc_job_t   slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= job_i;
  end

endmodule

// ===== hdl/tsc_back.sv =====
// Series evaluation on one shared 32x32 multiplier, sign and saturation.
module tsc_back import tsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  tsc_job_t              job_i,
  output logic                  pop_o,
  output logic [ValueWidth-1:0] value_o,
  output logic                  valid_o
);

  bk_state_e state_q, state_d;
  bk_step_e  step_q, step_d;

  logic [MagWidth-1:0]   a_q;
  logic                  neg_q;
  logic [31:0]           x2_q, t3_q, t5_q, t7_q, v_q;
  logic [ProdWidth-1:0]  prod_q;
  logic [ValueWidth-1:0] value_q;
  logic                  valid_q;

  logic                  do_mul;
  logic                  do_post;
  logic                  do_out;
  logic [31:0]           op_a, op_b;
  logic [ProdWidth-1:0]  rnd_sum;
  logic [RndWidth-1:0]   rnd;
  logic [RndWidth-1:0]   n_rnd;
  logic [31:0]           q0;
  logic [35:0]           dvsr;
  logic [35:0]           rem;
  logic [31:0]           q_fix;
  logic signed [35:0]    s_sum, s_sgn, s_x4;
  logic [ValueWidth-1:0] sat;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) state_d = BK_MUL;
      end
      BK_MUL:  state_d = BK_POST;
      BK_POST: state_d = (step_q == ST_DIV21) ? BK_OUT : BK_MUL;
      BK_OUT:  state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o   = 1'b0;
    do_mul  = 1'b0;
    do_post = 1'b0;
    do_out  = 1'b0;
    case (state_q)
      BK_IDLE: pop_o   = !empty_i;
      BK_MUL:  do_mul  = 1'b1;
      BK_POST: do_post = 1'b1;
      BK_OUT:  do_out  = 1'b1;
      default: ;
    endcase
  end

  // multiplier operand select
  always_comb begin
    op_a = 32'(a_q);
    op_b = 32'(a_q);
    case (step_q)
      ST_SQ:    begin op_a = 32'(a_q); op_b = 32'(a_q); end
      ST_CUBE:  begin op_a = x2_q;     op_b = 32'(a_q); end
      ST_DIV3:  begin op_a = v_q;      op_b = Recip3;   end
      ST_MUL5:  begin op_a = t3_q;     op_b = x2_q;     end
      ST_DIV5:  begin op_a = v_q;      op_b = Recip5;   end
      ST_MUL7:  begin op_a = t5_q;     op_b = x2_q;     end
      ST_DIV21: begin op_a = v_q;      op_b = Recip21;  end
      default: ;
    endcase
  end

  // round-half-up back to 28 fraction bits, then bias for rounded division
  always_comb begin
    rnd_sum = prod_q + (64'd1 << (PolyFrac - 1));
    rnd     = rnd_sum[ProdWidth-1:PolyFrac];
    n_rnd   = rnd;
    case (step_q)
      ST_CUBE: n_rnd = rnd + RndWidth'(3);
      ST_MUL5: n_rnd = rnd + RndWidth'(10);
      ST_MUL7: n_rnd = rnd + RndWidth'(21);
      default: ;
    endcase
  end

  // reciprocal quotient, low by at most one; one compare fixes it
  always_comb begin
    q0   = 32'(prod_q[63:33]);
    dvsr = 36'd3;
    case (step_q)
      ST_DIV5: begin
        q0   = 32'(prod_q[63:34]);
        dvsr = 36'd5;
      end
      ST_DIV21: begin
        q0   = 32'(prod_q[63:36]);
        dvsr = 36'd21;
      end
      default: ;
    endcase
    rem   = {4'd0, v_q} - ({4'd0, q0} * dvsr);
    q_fix = (rem >= dvsr) ? (q0 + 32'd1) : q0;
  end

  // x - x^3/6 + x^5/120 - x^7/5040, signed and scaled to Q2.30
  always_comb begin
    s_sum = $signed({6'd0, a_q}) - $signed({4'd0, t3_q})
          + $signed({4'd0, t5_q}) - $signed({4'd0, t7_q});
    s_sgn = neg_q ? -s_sum : s_sum;
    s_x4  = s_sgn <<< 2;
    if (s_x4 > 36'sd2147483647)       sat = 32'h7FFF_FFFF;
    else if (s_x4 < -36'sd2147483648) sat = 32'h8000_0000;
    else                              sat = s_x4[ValueWidth-1:0];
  end

  always_comb begin
    step_d = step_q;
    if (pop_o)                         step_d = ST_SQ;
    else if (do_post && step_q != ST_DIV21) step_d = bk_step_e'(step_q + 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= ST_SQ;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= do_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_q   <= job_i.mag;
      neg_q <= job_i.neg;
    end
    if (do_mul) prod_q <= 64'(op_a) * 64'(op_b);
    if (do_post) begin
      case (step_q)
        ST_SQ:    x2_q <= rnd[31:0];
        ST_CUBE:  v_q  <= n_rnd[32:1];
        ST_DIV3:  t3_q <= q_fix;
        ST_MUL5:  v_q  <= n_rnd[33:2];
        ST_DIV5:  t5_q <= q_fix;
        ST_MUL7:  v_q  <= n_rnd[32:1];
        ST_DIV21: t7_q <= q_fix;
        default: ;
      endcase
    end
    if (do_out) value_q <= sat;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ===== hdl/taylor_sine_cosine_top.sv =====
// Top level of the Taylor-series sine/cosine block.
// Overlap: the shared multiplier does seven multiply/post pairs per request, range
//   reduction one shift-subtract per cycle. A two-entry queue lets intake run ahead of
//   the series, so intake can take a new request before the last result is out.
// Reset: rst_ni clears both controllers and the queue; nothing is in flight after it.
// The result strobe cannot be held off: value_o is valid for the single valid_o cycle.
module taylor_sine_cosine_top import tsc_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode_i,
  input  logic [AngleWidth-1:0] angle_i,
  output logic [ValueWidth-1:0] value_o,
  output logic                  valid_o
);

  // front-to-back queue signals
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  tsc_job_t job_in;
  tsc_job_t job_out;

  // intake: cosine offset and reduction into [-pi, pi]
  tsc_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .mode_i   (mode_i),
    .angle_i  (angle_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .job_o    (job_in)
  );

  tsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (job_out)
  );

  // series evaluation in Q4.28, result in Q2.30
  tsc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .job_i   (job_out),
    .pop_o   (q_pop),
    .value_o (value_o),
    .valid_o (valid_o)
  );

endmodule
